FILE: rtl/core/bfbp_pkg.sv
// Shared types and codes for the best-fit buffer pool with aging.
package bfbp_pkg;

  // Default table depth and eviction cap per frame tick
  localparam int unsigned PoolDepth = 16;
  localparam int unsigned MaxEvict  = 16;
  localparam int unsigned EvictCntW = $clog2(MaxEvict + 1);

  // Operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RETURN  = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_HIT    = 3'd0;
  localparam logic [2:0] STAT_MISS   = 3'd1;
  localparam logic [2:0] STAT_STORED = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_EVICT  = 3'd4;
  localparam logic [2:0] STAT_DONE   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] req_size;
    logic [15:0] ret_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [31:0] out_size;
    logic [31:0] out_stamp;
    logic        last;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic [31:0] size;
    logic [15:0] handle;
    logic [31:0] stamp;
    logic [31:0] order;
  } entry_t;

  // Running best candidate of a scan
  typedef struct packed {
    logic        found;
    logic [31:0] size;
    logic [31:0] age;
  } best_t;

endpackage

FILE: rtl/core/best_fit_buffer_pool_with_aging.sv
// Best-fit free buffer pool with frame-based aging: sequencer and top level.
//
// Input channel (in_valid_i / in_stall_o) carries one item: request, return or
// frame tick. Results leave on out_valid_o / out_stall_i, one item per result,
// with last set on the final result of an input item. max_age_frames is written
// through cfg_valid_i / cfg_ready_o / cfg_data_i; the port is always ready.
// Each item is served by a scan of the whole table: the sequencer reads one
// entry per cycle from the entry memory and feeds it to a single compare unit.
// A request or return runs one scan of the table. A frame tick runs one scan per
// evicted entry plus one for the closing result, with at most 16 evictions per tick.
// The block takes no new item until the last result of the current item has
// been moved into the output register; that register lets the next item be
// accepted while a result still waits. A stalled receiver holds the result in
// the output register and pauses the sequencer at its next result.
// Reset clears the table (valid bits), the frame and insertion counters and
// sets max_age_frames to 3; no clearing pass is needed.
module best_fit_buffer_pool_with_aging #(
  parameter int unsigned POOL_DEPTH = bfbp_pkg::PoolDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bfbp_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bfbp_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned IdxW = $clog2(POOL_DEPTH);
  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned NW   = bfbp_pkg::EvictCntW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  // control state
  logic [1:0]            state_q, state_d;
  logic [31:0]           frame_q, frame_d;
  logic [31:0]           insert_q, insert_d;
  logic [15:0]           max_age_q, max_age_d;
  logic [POOL_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]       rd_cnt_q, rd_cnt_d;
  logic                  cmp_vld_q, cmp_vld_d;
  bfbp_pkg::best_t       best_q, best_d;
  logic [NW-1:0]         evict_n_q, evict_n_d;
  logic                  out_valid_q, out_valid_d;

  // payload state
  logic [1:0]            op_q, op_d;
  logic [31:0]           size_q, size_d;
  logic [15:0]           handle_q, handle_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [15:0]           best_handle_q, best_handle_d;
  logic [31:0]           best_stamp_q, best_stamp_d;
  bfbp_pkg::out_item_t   out_item_q, out_item_d;

  logic                  out_free;
  logic                  rd_busy;
  logic                  take;
  logic [31:0]           cand_age;
  bfbp_pkg::entry_t      rd_entry;
  bfbp_pkg::entry_t      wr_entry;
  logic                  mem_we;
  bfbp_pkg::out_item_t   res;
  logic                  res_clear;
  logic                  res_rescan;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_busy  = rd_cnt_q < CntW'(POOL_DEPTH);

  // entry memory
  assign wr_entry = '{size: size_q, handle: handle_q, stamp: frame_q, order: insert_q};

  bfbp_store #(
    .Depth (POOL_DEPTH),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (best_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_cnt_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // shared compare unit
  bfbp_cmp u_cmp (
    .op_i         (op_q),
    .slot_valid_i (valid_q[cmp_idx_q]),
    .entry_i      (rd_entry),
    .req_size_i   (size_q),
    .frame_i      (frame_q),
    .insert_i     (insert_q),
    .max_age_i    (max_age_q),
    .best_i       (best_q),
    .take_o       (take),
    .age_o        (cand_age)
  );

  // result of a finished scan
  always_comb begin
    res        = '0;
    res_clear  = 1'b0;
    res_rescan = 1'b0;
    mem_we     = 1'b0;
    unique case (op_q)
      bfbp_pkg::OP_REQUEST: begin
        if (best_q.found) begin
          res       = '{bfbp_pkg::STAT_HIT, best_handle_q, best_q.size, best_stamp_q, 1'b1};
          res_clear = 1'b1;
        end else begin
          res = '{bfbp_pkg::STAT_MISS, 16'd0, size_q, frame_q, 1'b1};
        end
      end
      bfbp_pkg::OP_RETURN: begin
        if (best_q.found) begin
          res    = '{bfbp_pkg::STAT_STORED, handle_q, size_q, frame_q, 1'b1};
          mem_we = (state_q == S_DECIDE) && out_free;
        end else begin
          res = '{bfbp_pkg::STAT_FULL, handle_q, size_q, 32'd0, 1'b1};
        end
      end
      bfbp_pkg::OP_TICK: begin
        if (best_q.found && (evict_n_q != NW'(bfbp_pkg::MaxEvict))) begin
          res        = '{bfbp_pkg::STAT_EVICT, best_handle_q, best_q.size, best_stamp_q, 1'b0};
          res_clear  = 1'b1;
          res_rescan = 1'b1;
        end else begin
          res = '{bfbp_pkg::STAT_DONE, 16'd0, 32'd0, frame_q, 1'b1};
        end
      end
      default: res = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    frame_d       = frame_q;
    insert_d      = insert_q;
    max_age_d     = max_age_q;
    valid_d       = valid_q;
    rd_cnt_d      = rd_cnt_q;
    cmp_vld_d     = cmp_vld_q;
    best_d        = best_q;
    evict_n_d     = evict_n_q;
    out_valid_d   = out_valid_q;
    op_d          = op_q;
    size_d        = size_q;
    handle_d      = handle_q;
    cmp_idx_d     = cmp_idx_q;
    best_idx_d    = best_idx_q;
    best_handle_d = best_handle_q;
    best_stamp_d  = best_stamp_q;
    out_item_d    = out_item_q;

    if (cfg_valid_i) begin
      max_age_d = cfg_data_i;
    end

    // output register drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.op;
          size_d   = in_item_i.req_size;
          handle_d = in_item_i.ret_handle;
          if (in_item_i.op == bfbp_pkg::OP_TICK) begin
            frame_d   = frame_q + 32'd1;
            evict_n_d = '0;
          end
          if (in_item_i.op != bfbp_pkg::OP_NONE) begin
            state_d    = S_SCAN;
            rd_cnt_d   = '0;
            cmp_vld_d  = 1'b0;
            best_d     = '0;
          end
        end
      end
      S_SCAN: begin
        // one read issued and one entry compared per cycle
        cmp_vld_d = rd_busy;
        cmp_idx_d = rd_cnt_q[IdxW-1:0];
        if (rd_busy) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        if (cmp_vld_q && take) begin
          best_d        = '{found: 1'b1, size: rd_entry.size, age: cand_age};
          best_idx_d    = cmp_idx_q;
          best_handle_d = rd_entry.handle;
          best_stamp_d  = rd_entry.stamp;
        end
        if (!rd_busy && !cmp_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res;
          if (res_clear) begin
            valid_d[best_idx_q] = 1'b0;
          end
          if (mem_we) begin
            valid_d[best_idx_q] = 1'b1;
            insert_d            = insert_q + 32'd1;
          end
          if (res_rescan) begin
            state_d   = S_SCAN;
            rd_cnt_d  = '0;
            cmp_vld_d = 1'b0;
            best_d    = '0;
            evict_n_d = evict_n_q + NW'(1);
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= '0;
      insert_q    <= '0;
      max_age_q   <= 16'd3;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      cmp_vld_q   <= 1'b0;
      best_q      <= '0;
      evict_n_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      insert_q    <= insert_d;
      max_age_q   <= max_age_d;
      valid_q     <= valid_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      best_q      <= best_d;
      evict_n_q   <= evict_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    size_q        <= size_d;
    handle_q      <= handle_d;
    cmp_idx_q     <= cmp_idx_d;
    best_idx_q    <= best_idx_d;
    best_handle_q <= best_handle_d;
    best_stamp_q  <= best_stamp_d;
    out_item_q    <= out_item_d;
  end

`ifndef SYNTHESIS
  // a store never lands on an occupied slot
  a_store_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !valid_q[best_idx_q])
    else $error("store into occupied slot");

  // hits and evictions only remove occupied slots
  a_clear_valid_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && out_free && res_clear) |-> valid_q[best_idx_q])
    else $error("removed entry was not valid");

  // eviction count per tick stays within the cap
  a_evict_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_n_q <= NW'(bfbp_pkg::MaxEvict))
    else $error("eviction count past cap");

  // a new result is only loaded once the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_item_q))
    else $error("pending result overwritten");
`endif

endmodule

FILE: rtl/core/bfbp_store.sv
// Entry memory of the buffer pool: one write port, one registered read port.
module bfbp_store #(
  parameter int unsigned Depth = bfbp_pkg::PoolDepth,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  bfbp_pkg::entry_t      wdata_i,
  input  logic [IdxW-1:0]       raddr_i,
  output bfbp_pkg::entry_t      rdata_o
);

  bfbp_pkg::entry_t mem [Depth];
  bfbp_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bfbp_cmp.sv
// Shared compare unit: decides whether the scanned entry replaces the current best.
module bfbp_cmp (
  input  logic [1:0]        op_i,
  input  logic              slot_valid_i,
  input  bfbp_pkg::entry_t  entry_i,
  input  logic [31:0]       req_size_i,
  input  logic [31:0]       frame_i,
  input  logic [31:0]       insert_i,
  input  logic [15:0]       max_age_i,
  input  bfbp_pkg::best_t   best_i,
  output logic              take_o,
  output logic [31:0]       age_o
);

  logic [31:0] age;
  logic [31:0] lag;
  logic        better;
  logic        fits;
  logic        expired;

  // insertion age: larger means older
  assign age = insert_i - entry_i.order;

  // smaller size wins, equal size goes oldest first
  assign better = !best_i.found || (entry_i.size < best_i.size) ||
                  ((entry_i.size == best_i.size) && (age > best_i.age));

  assign fits = entry_i.size >= req_size_i;

  // modular "stamp + max age below frame" test
  assign lag     = frame_i - entry_i.stamp - {16'd0, max_age_i};
  assign expired = (lag != 32'd0) && !lag[31];

  always_comb begin
    unique case (op_i)
      bfbp_pkg::OP_REQUEST: take_o = slot_valid_i && fits && better;
      bfbp_pkg::OP_RETURN:  take_o = !slot_valid_i && !best_i.found;
      bfbp_pkg::OP_TICK:    take_o = slot_valid_i && expired && better;
      default:              take_o = 1'b0;
    endcase
  end

  assign age_o = age;

endmodule
